@@ rtl/rllt_pkg.sv @@
// Shared types and constants of the run-length line table.
`default_nettype none
package rllt_pkg;

    // Size of the run table and width of a stored line number.
    localparam int MAX_RUNS  = 256;
    localparam int LINE_BITS = 16;
    localparam int CNT_BITS  = $clog2(MAX_RUNS + 1);

    // Largest byte count minus one that a single run may hold.
    localparam logic [7:0] RUN_EXTRA_LIMIT = 8'd255;

    // Status codes of a result.
    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    // Request codes.
    localparam logic REQ_APPEND = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    // One input transaction.
    typedef struct packed {
        logic        req_type;
        logic [15:0] line_number;
        logic [15:0] byte_offset;
    } t_req;

    // One result transaction.
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_line;
    } t_res;

    // Append command broadcast to every cell.
    typedef struct packed {
        logic                 grow;
        logic                 open;
        logic [LINE_BITS-1:0] line;
    } t_cmd;

    // Lookup token handed from cell to cell.
    typedef struct packed {
        logic                 active;
        logic                 done;
        logic                 hit;
        logic [LINE_BITS-1:0] line;
        logic [15:0]          rem;
    } t_tok;

endpackage
`default_nettype wire

@@ rtl/run_length_line_table_unit.sv @@
// Top level of the run-length line table: control, result register and the cell chain.
// An append is answered in the next cycle and busy stays low, so appends may
// follow each other in every cycle. A lookup enters the chain of MAX_RUNS cells and moves
// one cell per cycle whether or not it has been answered; busy is high while the token
// walks the chain and the result is registered once it leaves the last cell, so the wait
// is set by the length of the cell chain. Each result is shown for one cycle with
// o_strobe and the receiver cannot stall it. A new transaction may be started in the
// cycle that carries the previous result.
`default_nettype none
module run_length_line_table_unit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire rllt_pkg::t_req   i_req,
    output logic                  o_strobe,
    output rllt_pkg::t_res        o_res
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_WALK = 2'b10
    } t_state;

    t_state                         r_state;
    logic [rllt_pkg::CNT_BITS-1:0]  r_count;
    logic [rllt_pkg::LINE_BITS-1:0] r_last_line;
    logic [7:0]                     r_last_extra;
    logic                           r_strobe;
    rllt_pkg::t_res                 r_res;

    logic                           accept;
    logic [rllt_pkg::LINE_BITS-1:0] in_line;
    logic                           can_grow;
    logic                           is_full;
    rllt_pkg::t_cmd                 cmd;
    rllt_pkg::t_tok                 tok_in;
    rllt_pkg::t_tok                 tok_chain [rllt_pkg::MAX_RUNS];
    logic                           valid_chain [rllt_pkg::MAX_RUNS];
    rllt_pkg::t_tok                 tok_last;

    assign accept  = start && (r_state == S_IDLE);
    assign in_line = rllt_pkg::LINE_BITS'(i_req.line_number);

    // Append decision from the copy of the newest run.
    assign can_grow = (r_count != '0) && (r_last_line == in_line)
                      && (r_last_extra < rllt_pkg::RUN_EXTRA_LIMIT);
    assign is_full  = (r_count == rllt_pkg::CNT_BITS'(rllt_pkg::MAX_RUNS));

    always_comb begin
        cmd.grow = accept && (i_req.req_type == rllt_pkg::REQ_APPEND) && can_grow;
        cmd.open = accept && (i_req.req_type == rllt_pkg::REQ_APPEND) && !can_grow
                   && !is_full;
        cmd.line = in_line;
    end

    // Lookup token injected into the first cell.
    always_comb begin
        tok_in.active = accept && (i_req.req_type == rllt_pkg::REQ_LOOKUP);
        tok_in.done   = 1'b0;
        tok_in.hit    = 1'b0;
        tok_in.line   = '0;
        tok_in.rem    = i_req.byte_offset;
    end

    // The cell chain.
    for (genvar g = 0; g < rllt_pkg::MAX_RUNS; g++) begin : g_cell
        logic           prev_valid;
        logic           next_valid;
        rllt_pkg::t_tok cell_tok_in;

        if (g == 0) begin : g_first
            assign prev_valid  = 1'b1;
            assign cell_tok_in = tok_in;
        end else begin : g_rest
            assign prev_valid  = valid_chain[g-1];
            assign cell_tok_in = tok_chain[g-1];
        end

        if (g == rllt_pkg::MAX_RUNS - 1) begin : g_last
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_valid = valid_chain[g+1];
        end

        rllt_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_prev_valid (prev_valid),
            .i_next_valid (next_valid),
            .i_cmd        (cmd),
            .i_tok        (cell_tok_in),
            .o_valid      (valid_chain[g]),
            .o_tok        (tok_chain[g])
        );
    end

    assign tok_last = tok_chain[rllt_pkg::MAX_RUNS-1];

    // Control and run count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (i_req.req_type == rllt_pkg::REQ_LOOKUP) begin
                            r_state <= S_WALK;
                        end else begin
                            r_strobe <= 1'b1;
                            if (cmd.open) begin
                                r_count <= r_count + 1'b1;
                            end
                        end
                    end
                end
                S_WALK: begin
                    if (tok_last.active) begin
                        r_state  <= S_IDLE;
                        r_strobe <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Result payload and the copy of the newest run.
    always_ff @(posedge i_clk) begin
        if (cmd.grow) begin
            r_last_extra <= r_last_extra + 8'd1;
        end else if (cmd.open) begin
            r_last_line  <= in_line;
            r_last_extra <= 8'd0;
        end
        if (accept && (i_req.req_type == rllt_pkg::REQ_APPEND)) begin
            r_res.status     <= (cmd.grow || cmd.open) ? rllt_pkg::STATUS_OK
                                                       : rllt_pkg::STATUS_FULL;
            r_res.found_line <= 16'd0;
        end else if ((r_state == S_WALK) && tok_last.active) begin
            if (tok_last.done && tok_last.hit) begin
                r_res.status     <= rllt_pkg::STATUS_OK;
                r_res.found_line <= 16'(tok_last.line);
            end else begin
                r_res.status     <= rllt_pkg::STATUS_NOT_FOUND;
                r_res.found_line <= 16'd0;
            end
        end
    end

    assign busy     = (r_state == S_WALK);
    assign o_strobe = r_strobe;
    assign o_res    = r_res;

endmodule
`default_nettype wire

@@ rtl/rllt_cell.sv @@
// One cell of the run chain: holds a single run and serves a passing lookup token.
`default_nettype none
module rllt_cell (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_prev_valid,
    input  wire logic              i_next_valid,
    input  wire rllt_pkg::t_cmd    i_cmd,
    input  wire rllt_pkg::t_tok    i_tok,
    output logic                   o_valid,
    output rllt_pkg::t_tok         o_tok
);

    logic                          r_valid;
    logic [rllt_pkg::LINE_BITS-1:0] r_line;
    logic [7:0]                    r_extra;
    rllt_pkg::t_tok                r_tok;
    rllt_pkg::t_tok                n_tok;

    // Run storage: the first empty cell opens a run, the newest run grows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_cmd.open && !r_valid && i_prev_valid) begin
            r_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.open && !r_valid && i_prev_valid) begin
            r_line  <= i_cmd.line;
            r_extra <= 8'd0;
        end else if (i_cmd.grow && r_valid && !i_next_valid) begin
            r_extra <= r_extra + 8'd1;
        end
    end

    // Token step: an empty cell ends the walk, a run whose end passes the
    // offset answers it, otherwise the run's length is taken off the offset.
    always_comb begin
        n_tok = i_tok;
        if (i_tok.active && !i_tok.done) begin
            if (!r_valid) begin
                n_tok.done = 1'b1;
                n_tok.hit  = 1'b0;
            end else if (i_tok.rem <= {8'd0, r_extra}) begin
                n_tok.done = 1'b1;
                n_tok.hit  = 1'b1;
                n_tok.line = r_line;
            end else begin
                n_tok.rem = i_tok.rem - ({8'd0, r_extra} + 16'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.active <= 1'b0;
        end else begin
            r_tok.active <= n_tok.active;
        end
        r_tok.done <= n_tok.done;
        r_tok.hit  <= n_tok.hit;
        r_tok.line <= n_tok.line;
        r_tok.rem  <= n_tok.rem;
    end

    assign o_valid = r_valid;
    assign o_tok   = r_tok;

endmodule
`default_nettype wire

@@ rtl/rllt_checker.sv @@
// Port-level checks of the run-length line table, bound to the top level.
`default_nettype none
module rllt_checker (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           start,
    input  wire logic           busy,
    input  wire rllt_pkg::t_req i_req,
    input  wire logic           o_strobe,
    input  wire rllt_pkg::t_res o_res
);

    // An append transaction is answered in the very next cycle.
    a_append_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.req_type == rllt_pkg::REQ_APPEND) |=> o_strobe)
        else $error("append not answered in the next cycle");

    // A lookup transaction makes the block busy and gives no result at once.
    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && (i_req.req_type == rllt_pkg::REQ_LOOKUP) |=> busy && !o_strobe)
        else $error("lookup did not start a walk");

    // The end of a walk always delivers a result.
    a_walk_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_strobe)
        else $error("walk ended without a result");

    // A result that is not OK carries no line number.
    a_line_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && (o_res.status != rllt_pkg::STATUS_OK) |-> (o_res.found_line == 16'd0))
        else $error("line number on a failed result");

    // Status is always one of the defined codes.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_res.status == rllt_pkg::STATUS_OK)
                     || (o_res.status == rllt_pkg::STATUS_NOT_FOUND)
                     || (o_res.status == rllt_pkg::STATUS_FULL))
        else $error("undefined status code");

endmodule

bind run_length_line_table_unit rllt_checker u_rllt_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .i_req    (i_req),
    .o_strobe (o_strobe),
    .o_res    (o_res)
);
`default_nettype wire
